// ===== hw/rtl/rtc_datetime_validate_encode_assert.svh =====
// Assertion macros shared by the date/time encoder checker.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef RTC_DATETIME_VALIDATE_ENCODE_ASSERT_SVH
`define RTC_DATETIME_VALIDATE_ENCODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define RTCDVE_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RTCDVE_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== hw/rtl/rtcdve_pkg.sv =====
// Types, constants and helper functions for the date/time validate and BCD encoder.
// Used by every module of the block; depends on nothing.
package rtcdve_pkg;

   localparam logic [11:0] YEAR_BASE      = 12'd2000;
   localparam logic [11:0] YEAR_LIMIT     = 12'd2100;
   localparam logic [11:0] MIN_YEAR_RESET = 12'd2019;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_YEAR = 3'd0;

   // Input beat
   typedef struct packed {
      logic [5:0]  second_in;
      logic [5:0]  minute_in;
      logic [4:0]  hour_in;
      logic [4:0]  day_of_month;
      logic [3:0]  month_in;
      logic [11:0] year_in;
   } req_type;

   // Result beat
   typedef struct packed {
      logic        ok;
      logic [7:0]  sec_bcd;
      logic [7:0]  min_bcd;
      logic [7:0]  hour_bcd;
      logic [2:0]  weekday_bcd;
      logic [7:0]  date_bcd;
      logic [7:0]  month_bcd;
      logic [7:0]  year_bcd;
   } rsp_type;

   // Checked item between the check and encode stages
   typedef struct packed {
      logic        ok;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [6:0]  year_off;
      logic [6:0]  wk_sum;
      logic [2:0]  month_ofs;
   } chk_type;

   // Days in a month; 0 for a month code outside 1..12
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:                                        days = leap ? 5'd29 : 5'd28;
         default:                                     days = 5'd0;
      endcase
      return days;
   endfunction

   // Sakamoto month offset, indexed by month 1..12
   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] ofs;
      case (month)
         4'd1:    ofs = 3'd0;
         4'd2:    ofs = 3'd3;
         4'd3:    ofs = 3'd2;
         4'd4:    ofs = 3'd5;
         4'd5:    ofs = 3'd0;
         4'd6:    ofs = 3'd3;
         4'd7:    ofs = 3'd5;
         4'd8:    ofs = 3'd1;
         4'd9:    ofs = 3'd4;
         4'd10:   ofs = 3'd6;
         4'd11:   ofs = 3'd2;
         4'd12:   ofs = 3'd4;
         default: ofs = 3'd0;
      endcase
      return ofs;
   endfunction

   // Remainder by 7: fold octal digits (8 is 1 mod 7), then one subtract
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [5:0] f1;
      logic [3:0] f2;
      logic [3:0] r;
      f1 = {1'b0, x[7:3]} + {3'b000, x[2:0]};
      f2 = {1'b0, f1[5:3]} + {1'b0, f1[2:0]};
      r  = (f2 >= 4'd7) ? (f2 - 4'd7) : f2;
      return r[2:0];
   endfunction

   // Two BCD digits of a value 0..99 by shift-and-add-3
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [7:0] acc;
      acc = 8'd0;
      for (int i = 6; i >= 0; i--) begin
         if (acc[3:0] >= 4'd5) acc[3:0] = acc[3:0] + 4'd3;
         if (acc[7:4] >= 4'd5) acc[7:4] = acc[7:4] + 4'd3;
         acc = {acc[6:0], v[i]};
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/rtcdve_csr.sv =====
// Configuration register block: holds min_year behind an APB-style port.
// Depends on rtcdve_pkg.
module rtcdve_csr
   import rtcdve_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [11:0]           min_year
);

   logic [11:0] min_year_ff;
   logic [11:0] min_year_in;
   logic        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == REG_MIN_YEAR);

   // Take the low 12 bits on a write to the register
   always_comb begin
      min_year_in = min_year_ff;
      if (wr_hit) min_year_in = pwdata[11:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= MIN_YEAR_RESET;
      end else begin
         min_year_ff <= min_year_in;
      end
   end

   // Read back the register, zero elsewhere
   always_comb begin
      prdata = '0;
      if (paddr == REG_MIN_YEAR) prdata = {{(CSR_DATA_W-12){1'b0}}, min_year_ff};
   end

   assign min_year = min_year_ff;

endmodule

// ===== hw/rtl/rtcdve_check.sv =====
// Input capture stage and field check stage of the date/time encoder.
// Depends on rtcdve_pkg (req_type, chk_type, month_days, month_offset).
module rtcdve_check
   import rtcdve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] min_year,
   input  logic        in_valid,
   output logic        in_stall,
   input  req_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output chk_type     out_data
);

   logic    a_valid_ff, a_valid_in;
   req_type a_data_ff,  a_data_in;
   logic    b_valid_ff, b_valid_in;
   chk_type b_data_ff,  b_data_in;
   logic    a_ready, b_ready;

   // Stage flow: a stage moves when it is empty or its successor moves
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_stall = !a_ready;

   // Capture the input beat
   always_comb begin
      a_valid_in = a_valid_ff;
      a_data_in  = a_data_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
         if (in_valid) a_data_in = in_data;
      end
   end

   // Check fields and form the year part of the weekday sum
   logic [11:0] year_diff;
   logic [6:0]  year_off;
   logic        leap;
   logic        year_ok;
   logic        day_ok;
   logic        early;
   logic [6:0]  year_adj;
   chk_type     chk;

   always_comb begin
      year_diff = a_data_ff.year_in - YEAR_BASE;
      year_off  = year_diff[6:0];
      // Within 2000..2099 every fourth year is leap, 2000 included
      leap      = (year_off[1:0] == 2'b00);
      year_ok   = (a_data_ff.year_in >= min_year) && (a_data_ff.year_in < YEAR_LIMIT)
                  && (a_data_ff.year_in >= YEAR_BASE);
      day_ok    = (a_data_ff.day_of_month != 5'd0)
                  && (a_data_ff.day_of_month <= month_days(a_data_ff.month_in, leap));
      early     = (a_data_ff.month_in == 4'd1) || (a_data_ff.month_in == 4'd2);
      year_adj  = year_off - {6'd0, early};

      chk.ok        = year_ok && day_ok && (a_data_ff.month_in inside {[4'd1:4'd12]})
                      && (a_data_ff.hour_in <= 5'd23) && (a_data_ff.minute_in <= 6'd59)
                      && (a_data_ff.second_in <= 6'd59);
      chk.second    = a_data_ff.second_in;
      chk.minute    = a_data_ff.minute_in;
      chk.hour      = a_data_ff.hour_in;
      chk.day       = a_data_ff.day_of_month;
      chk.month     = a_data_ff.month_in;
      chk.year_off  = year_off;
      chk.month_ofs = month_offset(a_data_ff.month_in);
      // January and February of 2000 count as 1999, whose year term is 5 mod 7
      if (early && (year_off == 7'd0)) begin
         chk.wk_sum = 7'd5;
      end else begin
         chk.wk_sum = year_adj + {2'b00, year_adj[6:2]};
      end
   end

   // Hold or advance the checked beat
   always_comb begin
      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
         if (a_valid_ff) b_data_in = chk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_data_ff <= a_data_in;
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== hw/rtl/rtcdve_encode.sv =====
// Weekday and BCD encode stage of the date/time encoder; also the output register.
// Depends on rtcdve_pkg (chk_type, rsp_type, mod7, to_bcd).
module rtcdve_encode
   import rtcdve_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  chk_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    c_valid_ff, c_valid_in;
   rsp_type c_data_ff,  c_data_in;
   rsp_type enc;
   logic [7:0] total;

   assign in_ready = !c_valid_ff || !out_stall;

   // Finish the weekday and convert every field, zero the beat when the check failed
   always_comb begin
      total = {1'b0, in_data.wk_sum} + {5'd0, in_data.month_ofs} + {3'd0, in_data.day};
      enc   = '0;
      if (in_data.ok) begin
         enc.ok          = 1'b1;
         enc.sec_bcd     = to_bcd({1'b0, in_data.second});
         enc.min_bcd     = to_bcd({1'b0, in_data.minute});
         enc.hour_bcd    = to_bcd({2'b00, in_data.hour});
         enc.weekday_bcd = mod7(total) + 3'd1;
         enc.date_bcd    = to_bcd({2'b00, in_data.day});
         enc.month_bcd   = to_bcd({3'b000, in_data.month});
         enc.year_bcd    = to_bcd(in_data.year_off);
      end
   end

   // Hold the result while the receiver stalls
   always_comb begin
      c_valid_in = c_valid_ff;
      c_data_in  = c_data_ff;
      if (in_ready) begin
         c_valid_in = in_valid;
         if (in_valid) c_data_in = enc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_data_ff <= c_data_in;
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

// ===== hw/rtl/rtc_datetime_validate_encode.sv =====
// Date/time validate and BCD encoder for a real-time-clock register image.
// Depends on rtcdve_pkg, rtcdve_csr, rtcdve_check and rtcdve_encode.
//
// Usage:
//   req_*  : one date and time per beat (req_valid / req_stall / req_data).
//   rsp_*  : one result per beat: ok plus seven BCD bytes (rsp_valid / rsp_stall /
//            rsp_data). A date that fails any check comes out with ok and all
//            bytes zero.
//   psel..prdata : register min_year at byte address 0, 12 bits, reset 2019.
//            Write it only while no beat is in flight.
// Throughput: one beat per cycle while rsp_stall is low. Three register stages
//   (capture, check, encode); a beat passes through the capture, check and
//   encode registers in that order, and the encode register drives rsp_*.
// Reset (synchronous, active high) empties the pipeline and restores min_year;
//   there is no clearing pass, and beats are accepted right after reset.
// Stall: while rsp_stall is high the result holds on rsp_data. Upstream stages
//   keep filling bubbles, and req_stall rises only once all three stages are
//   full, in the same cycle as rsp_stall.
module rtc_datetime_validate_encode
   import rtcdve_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [11:0] min_year;
   logic        chk_valid;
   logic        chk_ready;
   chk_type     chk_data;

   rtcdve_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .min_year (min_year)
   );

   rtcdve_check u_check (
      .clock     (clock),
      .reset     (reset),
      .min_year  (min_year),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (chk_valid),
      .out_ready (chk_ready),
      .out_data  (chk_data)
   );

   rtcdve_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_data   (chk_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/rtcdve_checker.sv =====
// Port-level checker for the date/time encoder, bound to the top level.
// Depends on rtcdve_pkg and rtc_datetime_validate_encode_assert.svh.
`include "rtc_datetime_validate_encode_assert.svh"

module rtcdve_checker
   import rtcdve_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays put
   `RTCDVE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed under stall")

   // A failed check carries all-zero bytes
   `RTCDVE_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_data.ok, (rsp_data.sec_bcd == 8'd0) && (rsp_data.min_bcd == 8'd0) && (rsp_data.hour_bcd == 8'd0) && (rsp_data.weekday_bcd == 3'd0) && (rsp_data.date_bcd == 8'd0) && (rsp_data.month_bcd == 8'd0) && (rsp_data.year_bcd == 8'd0), "failed beat has nonzero bytes")

   // A passed check carries a weekday, a day, a month and legal second digits
   `RTCDVE_ASSERT_NOW(a_pass_fields, rsp_valid && rsp_data.ok, (rsp_data.weekday_bcd != 3'd0) && (rsp_data.date_bcd != 8'd0) && (rsp_data.month_bcd != 8'd0) && (rsp_data.sec_bcd[7:4] <= 4'd5) && (rsp_data.sec_bcd[3:0] <= 4'd9), "passed beat has an illegal field")

   // The pipeline is empty right after reset and can take a beat
   `RTCDVE_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind rtc_datetime_validate_encode rtcdve_checker u_checker (.*);

// ===== tb/rtc_datetime_validate_encode_checker.sv =====
// Scoreboard for the date/time validate and BCD encoder: predicts one register image per
// accepted date and compares it with each accepted result beat. Depends on rtcdve_pkg.
module rtc_datetime_encode_checker
   import rtcdve_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatch_count,
   output int                    images_due
);

   localparam logic [CSR_ADDR_W-1:0] MIN_YEAR_ADDR = CSR_ADDR_W'(4 * REG_MIN_YEAR);

   rsp_type     image_q[$];
   logic [11:0] floor_year;

   initial mismatch_count = 0;

   // Two decimal digits packed as BCD
   function automatic logic [7:0] bcd_byte(input int unsigned v);
      return 8'(((v / 10) % 10) << 4 | (v % 10));
   endfunction

   // Expected register image for one date and time under the given earliest year
   function automatic rsp_type encode_datetime(input req_type d, input logic [11:0] lo_year);
      rsp_type     img;
      int unsigned yr;
      int unsigned days;
      int unsigned shift;
      int unsigned wd;
      bit          leap;
      bit          good;
      img  = '0;
      yr   = d.year_in;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (d.month_in)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 30;
         4'd2:                                        days = leap ? 29 : 28;
         default:                                     days = 0;
      endcase
      good = (d.day_of_month >= 1) && (d.month_in >= 1) && (d.month_in <= 12)
         && (yr >= lo_year) && (yr >= YEAR_BASE) && (yr < YEAR_LIMIT)
         && (d.hour_in <= 23) && (d.minute_in <= 59) && (d.second_in <= 59)
         && (d.day_of_month <= days);
      if (!good) return img;
      // Sakamoto: January and February count as months of the year before
      case (d.month_in)
         4'd1, 4'd5:  shift = 0;
         4'd8:        shift = 1;
         4'd3, 4'd11: shift = 2;
         4'd2, 4'd6:  shift = 3;
         4'd9, 4'd12: shift = 4;
         4'd4, 4'd7:  shift = 5;
         default:     shift = 6;
      endcase
      wd = (d.month_in < 3) ? yr - 1 : yr;
      wd = (wd + wd / 4 - wd / 100 + wd / 400 + shift + d.day_of_month) % 7;
      img.ok          = 1'b1;
      img.sec_bcd     = bcd_byte(d.second_in);
      img.min_bcd     = bcd_byte(d.minute_in);
      img.hour_bcd    = bcd_byte(d.hour_in);
      img.weekday_bcd = 3'(wd + 1);
      img.date_bcd    = bcd_byte(d.day_of_month);
      img.month_bcd   = bcd_byte(d.month_in);
      img.year_bcd    = bcd_byte(yr - YEAR_BASE);
      return img;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Track min_year writes, queue a prediction per input beat, compare each result beat
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         image_q.delete();
         floor_year = MIN_YEAR_RESET;
         images_due <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == MIN_YEAR_ADDR)
            floor_year = pwdata[11:0];
         if (req_valid && !req_stall)
            image_q.push_back(encode_datetime(req_data, floor_year));
         if (rsp_valid && !rsp_stall) begin
            if (image_q.size() == 0) begin
               $display("%0t: result beat expected none actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = image_q.pop_front();
               check_field("ok", want.ok, rsp_data.ok);
               check_field("sec_bcd", want.sec_bcd, rsp_data.sec_bcd);
               check_field("min_bcd", want.min_bcd, rsp_data.min_bcd);
               check_field("hour_bcd", want.hour_bcd, rsp_data.hour_bcd);
               check_field("weekday_bcd", want.weekday_bcd, rsp_data.weekday_bcd);
               check_field("date_bcd", want.date_bcd, rsp_data.date_bcd);
               check_field("month_bcd", want.month_bcd, rsp_data.month_bcd);
               check_field("year_bcd", want.year_bcd, rsp_data.year_bcd);
            end
         end
         images_due <= image_q.size();
      end
   end

endmodule

// ===== tb/rtc_datetime_validate_encode_tb.sv =====
// Top of the date/time encoder testbench: clock, reset, date beats, result back-pressure,
// min_year writes and the verdict. Depends on rtcdve_pkg and rtc_datetime_encode_checker.
module rtc_datetime_validate_encode_tb;
   import rtcdve_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] MIN_YEAR_ADDR = CSR_ADDR_W'(4 * REG_MIN_YEAR);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    images_due;

   int          send_gap_pct;
   int          rsp_hold_pct;
   int          hold_left;
   int          idle_cycles;
   int unsigned floor_year;

   rtc_datetime_validate_encode dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   rtc_datetime_encode_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .mismatch_count(mismatch_count), .images_due(images_due)
   );

   always #10 clock = ~clock;

   // Drive result back-pressure: a requested long hold first, else random stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
         end
      end
   end

   // End the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Offer one beat after an optional random gap and hold it until accepted
   task automatic send_beat(input req_type d);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_datetime(input int unsigned s, input int unsigned mi, input int unsigned h,
                                input int unsigned d, input int unsigned mo, input int unsigned y);
      req_type dt;
      dt.second_in    = 6'(s);
      dt.minute_in    = 6'(mi);
      dt.hour_in      = 5'(h);
      dt.day_of_month = 5'(d);
      dt.month_in     = 4'(mo);
      dt.year_in      = 12'(y);
      send_beat(dt);
   endtask

   // Mostly well-formed dates in the accepted year span, then random noise on some fields and raw bits
   function automatic req_type make_datetime();
      req_type     dt;
      logic [63:0] raw;
      int unsigned pick;
      int unsigned first_year;
      pick       = $urandom_range(99);
      first_year = (floor_year > 2099 || floor_year < 2000) ? 2000 : floor_year;
      dt.second_in    = 6'($urandom_range(59));
      dt.minute_in    = 6'($urandom_range(59));
      dt.hour_in      = 5'($urandom_range(23));
      dt.day_of_month = 5'($urandom_range(31, 1));
      dt.month_in     = 4'($urandom_range(12, 1));
      dt.year_in      = 12'($urandom_range(2099, first_year));
      if (pick >= 90) begin
         raw = {$urandom, $urandom};
         dt  = raw[$bits(req_type)-1:0];
      end else if (pick >= 70) begin
         if ($urandom_range(3) == 0) dt.second_in    = 6'($urandom);
         if ($urandom_range(3) == 0) dt.minute_in    = 6'($urandom);
         if ($urandom_range(3) == 0) dt.hour_in      = 5'($urandom);
         if ($urandom_range(3) == 0) dt.day_of_month = 5'($urandom);
         if ($urandom_range(3) == 0) dt.month_in     = 4'($urandom);
         if ($urandom_range(3) == 0) dt.year_in      = 12'($urandom);
      end
      return dt;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_beat(make_datetime());
   endtask

   // Drop valid and hold until every predicted image has come back
   task automatic drain_images();
      req_valid <= 1'b0;
      do @(posedge clock); while (images_due != 0);
   endtask

   // Setup then access cycle on the register port, with the pipeline empty
   task automatic write_min_year(input int unsigned value);
      drain_images();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= MIN_YEAR_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      floor_year = value;
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      hold_left    = 0;
      idle_cycles  = 0;
      send_gap_pct = 20;
      rsp_hold_pct = 54;
      floor_year   = MIN_YEAR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and calendar corners under the reset earliest year
      send_datetime(0, 0, 0, 1, 1, 2019);
      send_datetime(59, 59, 23, 31, 12, 2018);
      send_datetime(59, 59, 23, 31, 12, 2099);
      send_datetime(0, 0, 0, 1, 1, 2100);
      send_datetime(45, 30, 12, 29, 2, 2020);
      send_datetime(0, 0, 0, 29, 2, 2021);
      send_datetime(0, 0, 0, 28, 2, 2021);
      send_datetime(1, 2, 3, 30, 4, 2024);
      send_datetime(1, 2, 3, 31, 4, 2024);
      send_datetime(0, 0, 0, 1, 13, 2024);
      send_datetime(0, 0, 0, 1, 0, 2024);
      send_datetime(0, 0, 0, 1, 15, 2024);
      send_datetime(0, 0, 0, 0, 6, 2024);
      send_datetime(0, 0, 24, 1, 6, 2024);
      send_datetime(0, 0, 31, 1, 6, 2024);
      send_datetime(0, 60, 0, 1, 6, 2024);
      send_datetime(0, 63, 0, 1, 6, 2024);
      send_datetime(60, 0, 0, 1, 6, 2024);
      send_datetime(63, 0, 0, 1, 6, 2024);
      send_datetime(0, 0, 0, 0, 0, 0);
      send_datetime(63, 63, 31, 31, 15, 4095);
      send_datetime(10, 20, 9, 15, 6, 4095);
      send_datetime(37, 48, 19, 31, 7, 2050);
      send_random(200);

      // Lowest earliest year: the year 2000 itself and its leap day
      write_min_year(2000);
      send_datetime(0, 0, 0, 1, 1, 2000);
      send_datetime(59, 59, 23, 29, 2, 2000);
      send_datetime(59, 59, 23, 31, 12, 1999);
      send_random(200);

      // Earliest year above the last valid year, then at it
      send_gap_pct = 54;
      rsp_hold_pct = 20;
      write_min_year(4095);
      send_random(80);
      write_min_year(2099);
      send_random(120);

      // No idling; hold results off long enough to back up the input
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      write_min_year(2037);
      hold_left = 40;
      send_random(24);
      drain_images();
      send_random(176);

      drain_images();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rtcdve_pkg.sv
hw/rtl/rtcdve_csr.sv
hw/rtl/rtcdve_check.sv
hw/rtl/rtcdve_encode.sv
hw/rtl/rtc_datetime_validate_encode.sv
hw/rtl/rtcdve_checker.sv
tb/rtc_datetime_validate_encode_checker.sv
tb/rtc_datetime_validate_encode_tb.sv
